// ===== hw/rtl/u64alu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u64alu_pkg: shared types and constants for the 64-bit arithmetic unit
// Opcode codes, datapath widths and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package u64alu_pkg;

    localparam int DATA_W = 64;
    localparam int OP_W   = 2;
    localparam int CNT_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } opcode_t;

    typedef struct packed {
        logic load;
        logic step_mul;
        logic step_div;
        logic res_div;
        logic out_load;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/u64alu_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u64alu_ctrl: sequencing controller
// Takes one word at a time, counts 64 multiply or divide steps and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module u64alu_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [u64alu_pkg::OP_W-1:0] opcode,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output u64alu_pkg::dp_cmd_t            cmd
);
    import u64alu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               div_reg, div_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;

    always_comb
    begin
        accept         = in_valid && (state_reg == ST_IDLE);
        in_ready       = (state_reg == ST_IDLE);
        out_valid      = out_valid_reg;

        cmd.load       = accept;
        cmd.step_mul   = (state_reg == ST_MUL);
        cmd.step_div   = (state_reg == ST_DIV);
        cmd.res_div    = div_reg;
        cmd.out_load   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        div_next       = div_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    div_next = (opcode_t'(opcode) == OP_DIV);
                    unique case (opcode_t'(opcode))
                        OP_ADD, OP_SUB: state_next = ST_DONE;
                        OP_MUL:         state_next = ST_MUL;
                        OP_DIV:         state_next = ST_DIV;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL, ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (cmd.out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            div_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            div_reg       <= div_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_steps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step_mul, cmd.step_div, cmd.out_load}))
        else $error("more than one datapath command at once");

    a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_mul || cmd.step_div) && (cnt_reg == '1) |=> state_reg == ST_DONE)
        else $error("iteration did not finish after 64 steps");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not posted to output register");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/u64alu_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u64alu_dp: arithmetic datapath
// 64-bit add and subtract, radix-2 shift-add multiply and
// radix-2 restoring divide, plus the output word register.
// ----------------------------------------------------------------------------
module u64alu_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire u64alu_pkg::dp_cmd_t           cmd,
    input  wire logic [u64alu_pkg::OP_W-1:0]   opcode,
    input  wire logic [u64alu_pkg::DATA_W-1:0] operand_a,
    input  wire logic [u64alu_pkg::DATA_W-1:0] operand_b,
    output logic      [u64alu_pkg::DATA_W-1:0] result_value,
    output logic                               divide_by_zero
);
    import u64alu_pkg::*;

    logic [DATA_W-1:0] acc_reg;     // sum, partial product or remainder
    logic [DATA_W-1:0] x_reg;       // multiplier or dividend/quotient
    logic [DATA_W-1:0] y_reg;       // multiplicand or divisor
    logic              dz_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_dz_reg;

    logic [DATA_W-1:0] add_res;
    logic [DATA_W-1:0] sub_res;
    logic [DATA_W-1:0] mul_sum;
    logic [DATA_W:0]   trial;
    logic [DATA_W+1:0] diff;
    logic              ge;
    logic [DATA_W-1:0] rem_next;

    always_comb
    begin
        add_res  = operand_a + operand_b;
        sub_res  = operand_a - operand_b;
        mul_sum  = acc_reg + (x_reg[0] ? y_reg : '0);
        trial    = {acc_reg, x_reg[DATA_W-1]};
        diff     = {1'b0, trial} - {2'b00, y_reg};
        ge       = !diff[DATA_W+1];
        rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            unique case (opcode_t'(opcode))
                OP_ADD:
                begin
                    acc_reg <= add_res;
                    x_reg   <= operand_a;
                    y_reg   <= operand_b;
                end
                OP_SUB:
                begin
                    acc_reg <= sub_res;
                    x_reg   <= operand_a;
                    y_reg   <= operand_b;
                end
                OP_MUL:
                begin
                    acc_reg <= '0;
                    x_reg   <= operand_b;
                    y_reg   <= operand_a;
                end
                OP_DIV:
                begin
                    acc_reg <= '0;
                    x_reg   <= operand_a;
                    y_reg   <= operand_b;
                end
                default:
                begin
                    acc_reg <= '0;
                    x_reg   <= operand_a;
                    y_reg   <= operand_b;
                end
            endcase
        end
        else if (cmd.step_mul)
        begin
            acc_reg <= mul_sum;
            x_reg   <= {1'b0, x_reg[DATA_W-1:1]};
            y_reg   <= {y_reg[DATA_W-2:0], 1'b0};
        end
        else if (cmd.step_div)
        begin
            acc_reg <= rem_next;
            x_reg   <= {x_reg[DATA_W-2:0], ge};
        end

        if (cmd.out_load)
        begin
            if (cmd.res_div)
            begin
                out_data_reg <= dz_reg ? '0 : x_reg;
            end
            else
            begin
                out_data_reg <= acc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg     <= 1'b0;
            out_dz_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                dz_reg <= (opcode_t'(opcode) == OP_DIV) && (operand_b == '0);
            end
            if (cmd.out_load)
            begin
                out_dz_reg <= dz_reg;
            end
        end
    end

    assign result_value   = out_data_reg;
    assign divide_by_zero = out_dz_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_div && (y_reg != '0) |=> acc_reg < y_reg)
        else $error("partial remainder not below divisor");

    a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && dz_reg |=> (out_data_reg == '0) && out_dz_reg)
        else $error("zero divisor gave nonzero quotient");

    a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !dz_reg || cmd.res_div)
        else $error("zero divisor flag raised outside divide");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/uint64_add_sub_mul_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uint64_add_sub_mul_div: unsigned 64-bit add/subtract/multiply/divide unit
// Stream in opcode and two operands, stream out one 64-bit word per input.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Add and subtract go from input accept
// straight to the done state; multiply and divide first run the 64-step
// shift-add multiply or restoring divide loop. The done state loads the output
// register once it is empty or being read, so a stalled output holds the unit.
// Results wrap modulo 2^64; multiply returns the low 64 product bits. Divide by
// zero returns 0 with tuser set. A finished word waits in the output register
// while the next input is accepted.
module uint64_add_sub_mul_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // [63:0] operand_a, [127:64] operand_b
    input  wire logic [1:0]   s_axis_tuser,  // [1:0] opcode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // [63:0] result_value
    output logic [0:0]        m_axis_tuser   // [0] divide_by_zero
);
    import u64alu_pkg::*;

    dp_cmd_t           cmd;
    logic [DATA_W-1:0] result_value;
    logic              divide_by_zero;

    u64alu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    u64alu_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .opcode         (s_axis_tuser),
        .operand_a      (s_axis_tdata[DATA_W-1:0]),
        .operand_b      (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .result_value   (result_value),
        .divide_by_zero (divide_by_zero)
    );

    assign m_axis_tdata    = result_value;
    assign m_axis_tuser[0] = divide_by_zero;

endmodule
`default_nettype wire

// ===== tb/alu_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker: result predictor and comparator for the 64-bit ALU
// Watches both stream channels, computes the expected word for every
// accepted input word and compares each output word in order.
// ----------------------------------------------------------------------------
module alu_result_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           checked
);
    import u64alu_pkg::*;

    typedef struct {
        bit [63:0] value;
        bit        div_zero;
    } alu_result_t;

    alu_result_t expected_words[$];

    function automatic alu_result_t alu_predict(opcode_t op, bit [63:0] a, bit [63:0] b);
        alu_result_t r;
        r.value    = '0;
        r.div_zero = 1'b0;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            default:
            begin
                if (b == '0)
                    r.div_zero = 1'b1;
                else
                    r.value = a / b;
            end
        endcase
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    always @(posedge clk)
    begin
        alu_result_t exp_r;
        if (!rst_n)
        begin
            expected_words.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_words.push_back(alu_predict(opcode_t'(s_tuser), s_tdata[63:0],
                                                     s_tdata[127:64]));
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word %h (div_zero %b)", m_tdata, m_tuser[0]);
                    errors++;
                end
                else
                begin
                    exp_r = expected_words.pop_front();
                    checked++;
                    if (m_tdata !== exp_r.value)
                    begin
                        $error("result_value: expected %h, actual %h", exp_r.value, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_r.div_zero)
                    begin
                        $error("divide_by_zero: expected %b, actual %b", exp_r.div_zero,
                               m_tuser[0]);
                        errors++;
                    end
                end
            end
        end
        pending <= expected_words.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream testbench for the unsigned 64-bit add/sub/mul/div unit
// Drives directed corner words and random words under three pacing modes
// plus one long output stall; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import u64alu_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_WORDS   = 1030;
    localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int errors;
    int pending;
    int checked;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_go = 1'b0;
    int op_count[4];
    int idle_cycles = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    uint64_add_sub_mul_div DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alu_result_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // output side: random backpressure plus one long hold-off on request
    always @(posedge clk)
    begin
        int  hold_left;
        bit  hold_done;
        if (!rst_n)
        begin
            hold_left = 0;
            hold_done = 1'b0;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_word(opcode_t op, bit [63:0] a, bit [63:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        op_count[op]++;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic bit [63:0] rand_operand();
        bit [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = 64'($urandom_range(255));
            1: v = {32'h0, $urandom};
            2: v = v >> $urandom_range(63);
            3:
            begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = ALL_ONES;
                    3: v = 64'd1 << $urandom_range(63);
                    default: v = ALL_ONES >> $urandom_range(63);
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_random(int count);
        opcode_t   op;
        bit [63:0] a;
        bit [63:0] b;
        for (int i = 0; i < count; i++)
        begin
            op = opcode_t'($urandom_range(3));
            a  = rand_operand();
            b  = rand_operand();
            if (op == OP_DIV && $urandom_range(19) == 0)
                b = '0;
            send_word(op, a, b);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        tx_idle_pct = 14;
        rx_idle_pct <= 67;
        send_word(OP_ADD, '0, '0);
        send_word(OP_ADD, ALL_ONES, 64'd1);
        send_word(OP_ADD, ALL_ONES, ALL_ONES);
        send_word(OP_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_word(OP_SUB, '0, 64'd1);
        send_word(OP_SUB, ALL_ONES, ALL_ONES);
        send_word(OP_SUB, '0, ALL_ONES);
        send_word(OP_SUB, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321);
        send_word(OP_MUL, ALL_ONES, ALL_ONES);
        send_word(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
        send_word(OP_MUL, '0, ALL_ONES);
        send_word(OP_MUL, 64'hFFFF, 64'h10000);
        send_word(OP_MUL, 64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF);
        send_word(OP_DIV, ALL_ONES, '0);
        send_word(OP_DIV, '0, '0);
        send_word(OP_DIV, 64'd5, 64'd7);
        send_word(OP_DIV, ALL_ONES, 64'd1);
        send_word(OP_DIV, ALL_ONES, ALL_ONES);
        send_word(OP_DIV, '0, 64'd5);
        send_word(OP_DIV, ALL_ONES, 64'h8000_0000_0000_0000);
        send_word(OP_DIV, 64'hFFFF_0000_FFFF_0000, 64'h1_0001);

        send_random(RANDOM_WORDS / 3);

        tx_idle_pct = 67;
        rx_idle_pct <= 14;
        send_random(RANDOM_WORDS / 3);

        // no pacing; output stalls for a long stretch while input keeps coming
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_go <= 1'b1;
        send_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d add, %0d sub, %0d mul and %0d div words with corner operands",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
        $display("%0d results checked under three pacing modes and a %0d-cycle output stall",
                 checked, HOLD_CYCLES);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/u64alu_pkg.sv
hw/rtl/u64alu_ctrl.sv
hw/rtl/u64alu_dp.sv
hw/rtl/uint64_add_sub_mul_div.sv
tb/alu_result_checker.sv
tb/tb.sv
